/* rtl/ffha_pkg.sv */
`default_nettype none
package ffha_pkg;

   localparam int unsigned OFF_W = 17;
   localparam int unsigned STORE_DEPTH = 16385;
   localparam int unsigned IDX_W = 15;
   localparam logic [OFF_W-1:0] HDR_SZ = 17'd8;
   localparam logic [OFF_W-1:0] POOL_MAX = 17'd65536;
   localparam logic [OFF_W-1:0] NULL_LINK = 17'h1FFFF;
   localparam logic [OFF_W-1:0] SPLIT_MIN = 17'd16;
   localparam logic [IDX_W-1:0] STEP_MAX = 15'd16385;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_NULL = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] request_bytes;
      logic [15:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
      logic [16:0] free_bytes;
      logic [16:0] min_free_bytes;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0] size;
      logic [OFF_W-1:0] link;
      logic             used;
   } hdr_type;

endpackage
`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator with an address-ordered, coalescing free list.
// Command port: present req_data and raise start while busy is low; the item
// is taken at that edge and busy stays high until its result is out.
// Result: rsp_valid pulses for one cycle with rsp_data (status, payload
// offset, current and lowest free byte counts). The receiver cannot stall;
// a new item may start in the cycle the result is shown.
// csr_wr_en/csr_wr_data set the pool size; it is latched by the first alloc,
// which builds the list in S_SETUP_E and S_SETUP_Z. Write it only while idle.
// Steps: block headers live in a single-port-read RAM with registered read,
// so every search hop passes S_AWAIT and S_AUSE and every reinsert hop
// S_ICHK, S_IWAIT and S_IUSE. An alloc walks to the first block that fits,
// relinks its predecessor and, when the block is split, reinserts the rest;
// a free walks the ordered list, merges with the lower and upper neighbors
// and relinks its predecessor. The walks grow longer with fragmentation.
// Reset clears the list state; the header RAM is not cleared and needs no
// clearing pass.
`default_nettype none
module first_fit_heap_allocator (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  ffha_pkg::req_type  req_data,
   output logic               rsp_valid,
   output ffha_pkg::rsp_type  rsp_data,
   input  wire                csr_wr_en,
   input  wire [16:0]         csr_wr_data
);
   typedef enum logic [4:0] {
      S_IDLE, S_SETUP_E, S_SETUP_Z, S_ACHK, S_AWAIT, S_AUSE, S_PWAIT, S_PUSE,
      S_SPLIT, S_INS, S_ICHK, S_IWAIT, S_IUSE, S_IMERGE, S_INEXT, S_NWAIT,
      S_NUSE, S_WRB, S_WRP, S_AFIN, S_FCHK, S_FWAIT, S_FUSE
   } state_type;

   state_type state_ff, state_in;
   logic [16:0] pool_ff;
   logic [16:0] first_ff, first_in, end_ff, end_in, free_ff, free_in, min_ff, min_in;
   logic ready_ff, ready_in;
   logic [16:0] addr_ff, addr_in;
   ffha_pkg::req_type req_ff, req_in;
   logic [17:0] want_ff, want_in;
   logic [16:0] cur_ff, cur_in, prev_ff, prev_in;
   logic at_start_ff, at_start_in;
   logic [14:0] steps_ff, steps_in;
   logic [16:0] csize_ff, csize_in, clink_ff, clink_in;
   logic [16:0] blk_ff, blk_in, bsize_ff, bsize_in, blink_ff, blink_in;
   logic bused_ff, bused_in;
   logic [16:0] it_ff, it_in, itsize_ff, itsize_in, nxt_ff, nxt_in;
   logic itused_ff, itused_in;
   logic ret_alloc_ff, ret_alloc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [15:0] payload_ff, payload_in;

   logic mem_we;
   logic [16:0] mem_woff;
   ffha_pkg::hdr_type mem_wdata, mem_rdata, rd_hdr;
   logic addr_ok;

   ffha_ram #(.WIDTH($bits(ffha_pkg::hdr_type)), .DEPTH(ffha_pkg::STORE_DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_woff[16:2]),
      .wdata (mem_wdata),
      .raddr (addr_ff[16:2]),
      .rdata (mem_rdata)
   );

   // out-of-range or unaligned offsets read as an all-zero header
   assign addr_ok = (addr_ff[1:0] == 2'd0) && !(addr_ff[16] && (addr_ff[15:0] != 16'd0));
   assign rd_hdr = addr_ok ? mem_rdata : '0;

   logic [16:0] pool_sat, end_calc;
   logic [17:0] want_calc;
   logic [16:0] rem;
   logic [16:0] free_sub;
   logic [15:0] hdr_off;

   always_comb begin
      pool_sat = (pool_ff > ffha_pkg::POOL_MAX) ? ffha_pkg::POOL_MAX : pool_ff;
      end_calc = (pool_sat >= ffha_pkg::HDR_SZ) ?
                 ((pool_sat - ffha_pkg::HDR_SZ) & ~17'd3) : 17'd0;
      want_calc = (18'(req_ff.request_bytes[16:0]) + 18'(ffha_pkg::HDR_SZ) + 18'd3)
                  & ~18'd3;
      rem = csize_ff - want_ff[16:0];
      free_sub = free_ff - csize_ff;
      hdr_off = req_ff.block_offset - ffha_pkg::HDR_SZ[15:0];

      state_in = state_ff;
      first_in = first_ff; end_in = end_ff; free_in = free_ff; min_in = min_ff;
      ready_in = ready_ff; addr_in = addr_ff; req_in = req_ff; want_in = want_ff;
      cur_in = cur_ff; prev_in = prev_ff; at_start_in = at_start_ff;
      steps_in = steps_ff; csize_in = csize_ff; clink_in = clink_ff;
      blk_in = blk_ff; bsize_in = bsize_ff; blink_in = blink_ff; bused_in = bused_ff;
      it_in = it_ff; itsize_in = itsize_ff; itused_in = itused_ff; nxt_in = nxt_ff;
      ret_alloc_in = ret_alloc_ff;
      rsp_valid_in = 1'b0; status_in = status_ff; payload_in = payload_ff;
      mem_we = 1'b0; mem_woff = '0; mem_wdata = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.opcode) begin
                  state_in = S_FCHK;
               end else if (!ready_ff) begin
                  state_in = S_SETUP_E;
               end else begin
                  state_in = S_ACHK;
               end
            end
         end
         S_SETUP_E: begin
            mem_we = 1'b1;
            mem_woff = end_calc;
            mem_wdata = '{size: '0, link: ffha_pkg::NULL_LINK, used: 1'b0};
            end_in = end_calc;
            free_in = end_calc;
            min_in = end_calc;
            first_in = '0;
            ready_in = 1'b1;
            state_in = (end_calc != '0) ? S_SETUP_Z : S_ACHK;
         end
         S_SETUP_Z: begin
            mem_we = 1'b1;
            mem_woff = '0;
            mem_wdata = '{size: end_ff, link: end_ff, used: 1'b0};
            state_in = S_ACHK;
         end
         S_ACHK: begin
            want_in = want_calc;
            if (req_ff.request_bytes[31] || (req_ff.request_bytes == 32'd0) ||
                (req_ff.request_bytes[30:17] != '0) || (want_calc > 18'(free_ff))) begin
               status_in = ffha_pkg::ST_REFUSED;
               payload_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cur_in = first_ff;
               addr_in = first_ff;
               at_start_in = 1'b1;
               steps_in = '0;
               state_in = S_AWAIT;
            end
         end
         S_AWAIT: state_in = S_AUSE;
         S_AUSE: begin
            if ((18'(rd_hdr.size) < want_ff) && (rd_hdr.link != ffha_pkg::NULL_LINK) &&
                (steps_ff < ffha_pkg::STEP_MAX)) begin
               prev_in = cur_ff;
               at_start_in = 1'b0;
               cur_in = rd_hdr.link;
               addr_in = rd_hdr.link;
               steps_in = steps_ff + 15'd1;
               state_in = S_AWAIT;
            end else begin
               csize_in = rd_hdr.size;
               clink_in = rd_hdr.link;
               if ((cur_ff == end_ff) || (18'(rd_hdr.size) < want_ff)) begin
                  status_in = ffha_pkg::ST_REFUSED;
                  payload_in = '0;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (at_start_ff) begin
                  first_in = rd_hdr.link;
                  state_in = S_SPLIT;
               end else begin
                  addr_in = prev_ff;
                  state_in = S_PWAIT;
               end
            end
         end
         S_PWAIT: state_in = S_PUSE;
         S_PUSE: begin
            mem_we = 1'b1;
            mem_woff = prev_ff;
            mem_wdata = '{size: rd_hdr.size, link: clink_ff, used: rd_hdr.used};
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (rem > ffha_pkg::SPLIT_MIN) begin
               mem_we = 1'b1;
               mem_woff = cur_ff + want_ff[16:0];
               mem_wdata = '{size: rem, link: ffha_pkg::NULL_LINK, used: 1'b0};
               csize_in = want_ff[16:0];
               blk_in = cur_ff + want_ff[16:0];
               bsize_in = rem;
               bused_in = 1'b0;
               ret_alloc_in = 1'b1;
               state_in = S_INS;
            end else begin
               state_in = S_AFIN;
            end
         end
         S_INS: begin
            it_in = '0;
            at_start_in = 1'b1;
            nxt_in = first_ff;
            steps_in = '0;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            if ((nxt_ff != ffha_pkg::NULL_LINK) && (nxt_ff != end_ff) && (nxt_ff < blk_ff) &&
                (steps_ff < ffha_pkg::STEP_MAX)) begin
               it_in = nxt_ff;
               at_start_in = 1'b0;
               addr_in = nxt_ff;
               steps_in = steps_ff + 15'd1;
               state_in = S_IWAIT;
            end else begin
               state_in = S_IMERGE;
            end
         end
         S_IWAIT: state_in = S_IUSE;
         S_IUSE: begin
            itsize_in = rd_hdr.size;
            itused_in = rd_hdr.used;
            nxt_in = rd_hdr.link;
            state_in = S_ICHK;
         end
         S_IMERGE: begin
            // merge with the lower neighbor when it touches
            if (!at_start_ff && ((18'(it_ff) + 18'(itsize_ff)) == 18'(blk_ff))) begin
               bsize_in = itsize_ff + bsize_ff;
               blk_in = it_ff;
               bused_in = itused_ff;
            end
            state_in = S_INEXT;
         end
         S_INEXT: begin
            if ((nxt_ff != ffha_pkg::NULL_LINK) && ((18'(blk_ff) + 18'(bsize_ff)) == 18'(nxt_ff)))
            begin
               if (nxt_ff != end_ff) begin
                  addr_in = nxt_ff;
                  state_in = S_NWAIT;
               end else begin
                  blink_in = end_ff;
                  state_in = S_WRB;
               end
            end else begin
               blink_in = nxt_ff;
               state_in = S_WRB;
            end
         end
         S_NWAIT: state_in = S_NUSE;
         S_NUSE: begin
            bsize_in = bsize_ff + rd_hdr.size;
            blink_in = rd_hdr.link;
            state_in = S_WRB;
         end
         S_WRB: begin
            mem_we = 1'b1;
            mem_woff = blk_ff;
            mem_wdata = '{size: bsize_ff, link: blink_ff, used: bused_ff};
            if (at_start_ff) begin
               first_in = blk_ff;
               state_in = ret_alloc_ff ? S_AFIN : S_IDLE;
            end else if (it_ff != blk_ff) begin
               state_in = S_WRP;
            end else begin
               state_in = ret_alloc_ff ? S_AFIN : S_IDLE;
            end
            if (!ret_alloc_ff && (state_in == S_IDLE)) begin
               status_in = ffha_pkg::ST_OK;
               payload_in = '0;
               rsp_valid_in = 1'b1;
            end
         end
         S_WRP: begin
            mem_we = 1'b1;
            mem_woff = it_ff;
            mem_wdata = '{size: itsize_ff, link: blk_ff, used: itused_ff};
            if (ret_alloc_ff) begin
               state_in = S_AFIN;
            end else begin
               status_in = ffha_pkg::ST_OK;
               payload_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_AFIN: begin
            mem_we = 1'b1;
            mem_woff = cur_ff;
            mem_wdata = '{size: csize_ff, link: ffha_pkg::NULL_LINK, used: 1'b1};
            free_in = free_sub;
            if (free_sub < min_ff) begin
               min_in = free_sub;
            end
            status_in = ffha_pkg::ST_OK;
            payload_in = cur_ff[15:0] + ffha_pkg::HDR_SZ[15:0];
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_FCHK: begin
            payload_in = '0;
            if (req_ff.block_offset == 16'd0) begin
               status_in = ffha_pkg::ST_NULL;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if ((req_ff.block_offset < ffha_pkg::HDR_SZ[15:0]) ||
                         (hdr_off[1:0] != 2'd0)) begin
               status_in = ffha_pkg::ST_IGNORED;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               addr_in = {1'b0, hdr_off};
               state_in = S_FWAIT;
            end
         end
         S_FWAIT: state_in = S_FUSE;
         S_FUSE: begin
            if (!rd_hdr.used || (rd_hdr.link != ffha_pkg::NULL_LINK)) begin
               status_in = ffha_pkg::ST_IGNORED;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_we = 1'b1;
               mem_woff = addr_ff;
               mem_wdata = '{size: rd_hdr.size, link: rd_hdr.link, used: 1'b0};
               free_in = free_ff + rd_hdr.size;
               blk_in = addr_ff;
               bsize_in = rd_hdr.size;
               bused_in = 1'b0;
               ret_alloc_in = 1'b0;
               state_in = S_INS;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pool_ff <= '0;
         first_ff <= '0;
         end_ff <= '0;
         free_ff <= '0;
         min_ff <= '0;
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            pool_ff <= csr_wr_data;
         end
         first_ff <= first_in;
         end_ff <= end_in;
         free_ff <= free_in;
         min_ff <= min_in;
         ready_ff <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff <= addr_in;
      req_ff <= req_in;
      want_ff <= want_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      at_start_ff <= at_start_in;
      steps_ff <= steps_in;
      csize_ff <= csize_in;
      clink_ff <= clink_in;
      blk_ff <= blk_in;
      bsize_ff <= bsize_in;
      blink_ff <= blink_in;
      bused_ff <= bused_in;
      it_ff <= it_in;
      itsize_ff <= itsize_in;
      itused_ff <= itused_in;
      nxt_ff <= nxt_in;
      ret_alloc_ff <= ret_alloc_in;
      status_ff <= status_in;
      payload_ff <= payload_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = '{status: status_ff, payload_offset: payload_ff,
                       free_bytes: free_ff, min_free_bytes: min_ff};
endmodule
`default_nettype wire

/* rtl/ffha_ram.sv */
`default_nettype none
module ffha_ram #(
   parameter int unsigned WIDTH = 35,
   parameter int unsigned DEPTH = 16385
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
